// File: hw/rtl/josephus_elimination_order_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef JOSEPHUS_ELIMINATION_ORDER_ASSERT_SVH
`define JOSEPHUS_ELIMINATION_ORDER_ASSERT_SVH

// Checked at every edge outside reset.
`define JEO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define JEO_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/jeo_pkg.sv
package jeo_pkg;

  localparam int SIZE_W     = 7;
  localparam int STEP_W     = 16;
  localparam int MEMBER_W   = 7;
  localparam int STEP_CNT_W = $clog2(STEP_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_ROUND,
    ST_MOD,
    ST_WALK,
    ST_SCAN,
    ST_EMIT,
    ST_SURV
  } jeo_state_t;

endpackage

// File: hw/rtl/jeo_req_if.sv
interface jeo_req_if
  import jeo_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SIZE_W-1:0]   circle_size;
  logic [STEP_W-1:0]   count_step;

  modport source (output valid, output circle_size, output count_step, input ready);
  modport sink (input valid, input circle_size, input count_step, output ready);
endinterface

// File: hw/rtl/jeo_res_if.sv
interface jeo_res_if
  import jeo_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [MEMBER_W-1:0] member;
  logic                last;

  modport source (output valid, output member, output last, input ready);
  modport sink (input valid, input member, input last, output ready);
endinterface

// File: hw/rtl/jeo_alive_mem.sv
module jeo_alive_mem
  import jeo_pkg::*;
#(
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/jeo_mod_unit.sv
module jeo_mod_unit
  import jeo_pkg::*;
#(
  parameter int MAX_COUNT = 64,
  localparam int CW = $clog2(MAX_COUNT + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [STEP_W-1:0] dividend,
  input  logic [CW-1:0]     divisor,
  output logic              done,
  output logic [CW-1:0]     result
);

  logic                  busy;
  logic [STEP_CNT_W-1:0] cnt;
  logic [CW-1:0]         rem_q;
  logic [CW-1:0]         div_q;
  logic [STEP_W-1:0]     dvd;
  logic [CW:0]           trial;
  logic [CW-1:0]         rem_next;

  always_comb begin
    trial = {rem_q, dvd[STEP_W-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_next = CW'(trial - {1'b0, div_q});
    end else begin
      rem_next = trial[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt   <= STEP_CNT_W'(STEP_W - 1);
      rem_q <= '0;
      div_q <= divisor;
      dvd   <= dividend;
    end else if (busy) begin
      cnt   <= cnt - 1'b1;
      rem_q <= rem_next;
      dvd   <= {dvd[STEP_W-2:0], 1'b0};
    end
  end

  assign result = rem_q;

endmodule

// File: hw/rtl/josephus_elimination_order.sv
// Josephus elimination order. Each request word gives a circle size (clamped to MAX_MEMBERS)
// and a counting step; the block returns the eliminated members in order and then the
// survivor with last set, one request at a time. Live flags sit in a one-bit memory with a
// registered read. A request is accepted and its circle is then marked live, one member at a
// time. Each elimination then runs a bit-serial modulo of step minus one by the live count,
// walks to the victim, stepping over live members and skipping dead ones, and then finds the
// victim's successor, again skipping dead members. A stalled result word holds the block. A
// size of zero gives no word at all. The next request is taken from the cycle after the
// survivor is loaded into the output register.
module josephus_elimination_order
  import jeo_pkg::*;
#(
  parameter int MAX_MEMBERS = 64
) (
  input  logic      clk,
  input  logic      rst,
  jeo_req_if.sink   req,
  jeo_res_if.source res
);

  localparam int AW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam int CW = $clog2(MAX_MEMBERS + 1);

  jeo_state_t state, state_next;

  logic [CW-1:0]       size_n;
  logic [STEP_W-1:0]   step_m1;
  logic [CW-1:0]       remaining;
  logic [AW-1:0]       position;
  logic [CW-1:0]       step_counter;
  logic [AW-1:0]       fill;
  logic [AW-1:0]       probe;
  logic [AW-1:0]       pend_addr;
  logic                pend_v;
  logic                scan_kill;
  logic                out_valid;
  logic [MEMBER_W-1:0] out_member;
  logic                out_last;

  logic [CW-1:0]       n_in;
  logic                accept;
  logic                out_free;
  logic                fill_last;
  logic                found;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic                mem_wdata;
  logic                mem_rdata;
  logic                mod_start;
  logic                mod_done;
  logic [CW-1:0]       mod_result;
  logic                out_load;
  logic [AW:0]         pos_plus1;

  function automatic logic [AW-1:0] succ(input logic [AW-1:0] p, input logic [CW-1:0] n);
    logic [AW:0] p1;
    p1 = {1'b0, p} + 1'b1;
    return (p1 == (AW+1)'(n)) ? '0 : p1[AW-1:0];
  endfunction

  always_comb begin
    if (32'(req.circle_size) > 32'(MAX_MEMBERS)) begin
      n_in = CW'(MAX_MEMBERS);
    end else begin
      n_in = CW'(req.circle_size);
    end
  end

  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || res.ready;
  assign fill_last = ({1'b0, fill} + 1'b1) == (AW+1)'(size_n);
  assign found     = (state == ST_SCAN) && pend_v && mem_rdata;
  assign pos_plus1 = {1'b0, position} + 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.valid && n_in != '0) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        if (fill_last) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_next = (remaining > CW'(1)) ? ST_MOD : ST_SURV;
      end
      ST_MOD: begin
        if (mod_done) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        state_next = (step_counter == '0) ? ST_EMIT : ST_SCAN;
      end
      ST_SCAN: begin
        if (found) begin
          state_next = scan_kill ? ST_ROUND : ST_WALK;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_SCAN;
        end
      end
      ST_SURV: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = fill;
    mem_wdata = 1'b1;
    mod_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE: req.ready = 1'b1;
      ST_FILL: mem_we = 1'b1;
      ST_ROUND: mod_start = remaining > CW'(1);
      ST_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          mem_we    = 1'b1;
          mem_waddr = position;
          mem_wdata = 1'b0;
        end
      end
      ST_SURV: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
    end else if (state == ST_SCAN) begin
      pend_v <= !found;
    end else begin
      pend_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      size_n    <= n_in;
      step_m1   <= (req.count_step == '0) ? '0 : req.count_step - 1'b1;
      remaining <= n_in;
      position  <= '0;
      fill      <= '0;
    end
    if (state == ST_FILL) begin
      fill <= fill + 1'b1;
    end
    if (state == ST_MOD && mod_done) begin
      step_counter <= mod_result;
    end
    if (state == ST_WALK && step_counter != '0) begin
      probe     <= succ(position, size_n);
      scan_kill <= 1'b0;
    end
    if (state == ST_SCAN) begin
      probe     <= succ(probe, size_n);
      pend_addr <= probe;
      if (found) begin
        position <= pend_addr;
        if (!scan_kill) begin
          step_counter <= step_counter - 1'b1;
        end
      end
    end
    if (state == ST_EMIT && out_free) begin
      remaining <= remaining - 1'b1;
      probe     <= succ(position, size_n);
      scan_kill <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_member <= MEMBER_W'(pos_plus1);
      out_last   <= (state == ST_SURV);
    end
  end

  assign res.valid  = out_valid;
  assign res.member = out_member;
  assign res.last   = out_last;

  jeo_alive_mem #(
    .DEPTH (MAX_MEMBERS)
  ) u_alive_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (probe),
    .rdata (mem_rdata)
  );

  jeo_mod_unit #(
    .MAX_COUNT (MAX_MEMBERS)
  ) u_mod_unit (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (step_m1),
    .divisor  (remaining),
    .done     (mod_done),
    .result   (mod_result)
  );

endmodule

// File: hw/rtl/jeo_checker.sv
`include "josephus_elimination_order_assert.svh"

module jeo_checker
  import jeo_pkg::*;
#(
  parameter int MAX_MEMBERS = 64
) (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic [SIZE_W-1:0]   req_circle_size,
  input logic                res_valid,
  input logic                res_ready,
  input logic [MEMBER_W-1:0] res_member,
  input logic                res_last
);

  `JEO_ASSERT_RST(a_idle_after_reset, rst |=> !res_valid, "result word valid after reset")
  `JEO_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res_member) && $stable(res_last), "stalled result word changed")
  `JEO_ASSERT(a_member_range, res_valid |-> (MAX_MEMBERS > 127) || (res_member != 0 && 32'(res_member) <= MAX_MEMBERS), "member number out of range")
  `JEO_ASSERT(a_busy_after_req, req_valid && req_ready && req_circle_size != 0 |=> !req_ready, "new request taken while a circle is in work")
  `JEO_ASSERT(a_mid_result_busy, res_valid && !res_last |-> !req_ready, "request taken before the survivor word")

endmodule

bind josephus_elimination_order jeo_checker #(
  .MAX_MEMBERS (MAX_MEMBERS)
) u_jeo_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .req_circle_size (req.circle_size),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .res_member      (res.member),
  .res_last        (res.last)
);

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import jeo_pkg::*;

  localparam int MAX_MEMBERS = 64;
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 300;
  localparam int CHUNK_ITEMS = 30;

  typedef struct packed {
    logic [MEMBER_W-1:0] member;
    logic                last;
  } member_word_t;

  class elimination_tracker;
    member_word_t pending_members[$];
    bit           alive[MAX_MEMBERS];
    int           mismatches;

    function int next_alive(int pos, int n);
      int tries;
      for (tries = 0; tries < n; tries++) begin
        pos = (pos + 1) % n;
        if (alive[pos]) return pos;
      end
      return pos;
    endfunction

    function void add_request(logic [SIZE_W-1:0] size, logic [STEP_W-1:0] step);
      int n;
      int pos;
      int left;
      int walk;
      int stride;
      n = (size > MAX_MEMBERS) ? MAX_MEMBERS : int'(size);
      stride = (step == 0) ? 0 : int'(step) - 1;
      for (int i = 0; i < MAX_MEMBERS; i++) alive[i] = (i < n);
      if (n == 0) return;
      pos = 0;
      left = n;
      while (left > 1) begin
        walk = stride % left;
        while (walk > 0) begin
          pos = next_alive(pos, n);
          walk--;
        end
        pending_members.push_back('{member: MEMBER_W'(pos + 1), last: 1'b0});
        alive[pos] = 1'b0;
        left--;
        pos = next_alive(pos, n);
      end
      pending_members.push_back('{member: MEMBER_W'(pos + 1), last: 1'b1});
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_member(logic [MEMBER_W-1:0] member, logic last);
      member_word_t want;
      if (pending_members.size() == 0) begin
        report($sformatf("unexpected word member=%0d last=%0b", member, last));
        return;
      end
      want = pending_members.pop_front();
      if (member !== want.member)
        report($sformatf("member %0d, expected %0d", member, want.member));
      if (last !== want.last)
        report($sformatf("last %0b on member %0d, expected %0b", last, member, want.last));
    endtask

    function int outstanding();
      return pending_members.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   tx_idle;
  bit   rx_idle;
  bit   rx_hold;
  int   quiet_cycles;
  elimination_tracker tracker;

  jeo_req_if req();
  jeo_res_if res();

  josephus_elimination_order #(.MAX_MEMBERS(MAX_MEMBERS)) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .res(res)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_request(logic [SIZE_W-1:0] size, logic [STEP_W-1:0] step);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.circle_size <= size;
    req.count_step <= step;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    tracker.add_request(size, step);
  endtask

  task automatic send_random_request();
    int pick;
    logic [SIZE_W-1:0] size;
    logic [STEP_W-1:0] step;
    pick = $urandom_range(0, 99);
    if (pick < 70) size = SIZE_W'($urandom_range(1, 12));
    else if (pick < 80) size = '0;
    else if (pick < 90) size = SIZE_W'($urandom_range(13, 63));
    else size = SIZE_W'($urandom_range(64, 127));
    if ($urandom_range(0, 9) < 4) step = STEP_W'($urandom_range(0, 20));
    else step = STEP_W'($urandom);
    send_request(size, step);
  endtask

  task automatic wait_all_results();
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    int gap;
    bit hold_done;
    hold_done = 1'b0;
    res.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold && !hold_done) begin
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      gap = rx_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        res.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res.ready <= 1'b1;
      @(posedge clk);
      while (!res.valid) @(posedge clk);
      tracker.check_member(res.member, res.last);
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    tracker = new();
    rst = 1'b1;
    req.valid = 1'b0;
    req.circle_size = '0;
    req.count_step = '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    rx_hold = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(1, 0);
    send_request(1, 16'hFFFF);
    send_request(0, 5);
    send_request(0, 16'hFFFF);
    send_request(2, 0);
    send_request(2, 1);
    send_request(2, 2);
    send_request(2, 3);
    send_request(3, 16'hFFFE);
    send_request(5, 16'hAAAA);
    send_request(7, 3);
    send_request(10, 10);
    send_request(41, 3);
    send_request(64, 0);
    send_request(64, 64);
    send_request(64, 16'hFFFF);
    send_request(65, 7);
    send_request(100, 1);
    send_request(127, 16'h5555);

    for (int chunk = 0; chunk < 4; chunk++) begin
      tx_idle = (chunk != 1);
      rx_idle = (chunk != 1);
      if (chunk == 2) rx_hold = 1'b1;
      if (chunk == 3) begin
        req.valid <= 1'b0;
        @(posedge clk);
        wait_all_results();
      end
      for (int i = 0; i < CHUNK_ITEMS; i++) send_random_request();
    end
    req.valid <= 1'b0;

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
